/* rtl/core/packet_header_checker_unit_macros.svh */
// Assertion macros for the packet header checker.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef PACKET_HEADER_CHECKER_UNIT_MACROS_SVH
`define PACKET_HEADER_CHECKER_UNIT_MACROS_SVH

// Antecedent in the same cycle implies the consequent.
`define PHC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packet header checker: assertion failed");

// Antecedent implies the consequent in the next cycle.
`define PHC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packet header checker: assertion failed");

`endif

/* rtl/core/phc_pkg.sv */
// Shared types and constants for the packet header checker.
// No dependencies.
package phc_pkg;

	localparam int MAGIC_BYTES_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam logic [16:0] PAYLOAD_MAX = 17'h10000;

	typedef enum logic [0:0] {
		REG_MAGIC   = 1'b0,
		REG_VERSION = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_TRUNC   = 3'd1,
		ST_MAGIC   = 3'd2,
		ST_VERSION = 3'd3,
		ST_LENGTH  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		KIND_MAGIC   = 3'd0,
		KIND_VERSION = 3'd1,
		KIND_TYPE    = 3'd2,
		KIND_LENGTH  = 3'd3,
		KIND_SEQ     = 3'd4,
		KIND_PAYLOAD = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		kind_t      kind;
		logic       byte_ok;
		logic       complete;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  msg_type;
		logic [15:0] declared_length;
		logic [31:0] sequence_res;
		logic [7:0]  version_seen;
	} result_t;

endpackage

/* rtl/core/phc_queue.sv */
// Short FIFO of classified items between front and back.
// Depends on phc_pkg.
module phc_queue #(
	parameter int DEPTH = phc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  phc_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output phc_pkg::item_t  head
);
	import phc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/phc_front.sv */
// Front end: tracks header position, classifies each byte, checks magic bytes.
// Depends on phc_pkg.
module phc_front #(
	parameter int MAGIC_BYTES = phc_pkg::MAGIC_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	input  logic [31:0]     magic_word,
	output phc_pkg::item_t  item
);
	import phc_pkg::*;

	localparam int HDR_LEN = MAGIC_BYTES + 8;
	localparam int POS_W   = $clog2(HDR_LEN + 1);
	localparam int IDX_W   = (MAGIC_BYTES > 1) ? $clog2(MAGIC_BYTES) : 1;
	localparam int MW      = MAGIC_BYTES * 8;

	logic [POS_W-1:0] pos_q;
	logic [MW-1:0]    magic_full;
	logic [7:0]       exp_byte [MAGIC_BYTES];

	assign magic_full = MW'(magic_word);

	always_comb begin
		for (int i = 0; i < MAGIC_BYTES; i++) begin
			exp_byte[i] = magic_full[(MAGIC_BYTES - 1 - i) * 8 +: 8];
		end
	end

	always_comb begin
		item.data     = data_byte;
		item.last     = last_byte;
		item.byte_ok  = 1'b1;
		item.complete = 1'b1;
		if (pos_q < POS_W'(MAGIC_BYTES)) begin
			item.kind    = KIND_MAGIC;
			item.byte_ok = (data_byte == exp_byte[pos_q[IDX_W-1:0]]);
		end else if (pos_q == POS_W'(MAGIC_BYTES)) begin
			item.kind = KIND_VERSION;
		end else if (pos_q == POS_W'(MAGIC_BYTES + 1)) begin
			item.kind = KIND_TYPE;
		end else if (pos_q < POS_W'(MAGIC_BYTES + 4)) begin
			item.kind = KIND_LENGTH;
		end else if (pos_q < POS_W'(HDR_LEN)) begin
			item.kind = KIND_SEQ;
		end else begin
			item.kind = KIND_PAYLOAD;
		end
		if (pos_q < POS_W'(HDR_LEN - 1)) begin
			item.complete = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q <= '0;
			end else if (pos_q < POS_W'(HDR_LEN)) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

/* rtl/core/phc_back.sv */
// Back end: captures header fields, counts payload, forms the result.
// Depends on phc_pkg.
module phc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  phc_pkg::item_t   q_item,
	output logic             q_pop,
	input  logic [7:0]       expected_version,
	output logic             res_valid,
	input  logic             res_ready,
	output phc_pkg::result_t res
);
	import phc_pkg::*;

	logic        magic_ok_q;
	logic [7:0]  version_q;
	logic [7:0]  type_q;
	logic [15:0] length_q;
	logic [31:0] seq_q;
	logic [16:0] count_q;
	logic        res_valid_q;
	result_t     res_q;

	logic        magic_ok_n;
	logic [7:0]  version_n;
	logic [7:0]  type_n;
	logic [15:0] length_n;
	logic [31:0] seq_n;
	logic [16:0] count_n;
	result_t     res_n;

	assign q_pop     = q_valid && (!q_item.last || !res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		magic_ok_n = magic_ok_q;
		version_n  = version_q;
		type_n     = type_q;
		length_n   = length_q;
		seq_n      = seq_q;
		count_n    = count_q;
		unique case (q_item.kind)
			KIND_MAGIC:   magic_ok_n = magic_ok_q & q_item.byte_ok;
			KIND_VERSION: version_n  = q_item.data;
			KIND_TYPE:    type_n     = q_item.data;
			KIND_LENGTH:  length_n   = {length_q[7:0], q_item.data};
			KIND_SEQ:     seq_n      = {seq_q[23:0], q_item.data};
			KIND_PAYLOAD: begin
				if (count_q != PAYLOAD_MAX) begin
					count_n = count_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res_n = '0;
		if (!q_item.complete) begin
			res_n.status = ST_TRUNC;
		end else begin
			res_n.msg_type        = type_n;
			res_n.declared_length = length_n;
			res_n.sequence_res    = seq_n;
			res_n.version_seen    = version_n;
			if (!magic_ok_n) begin
				res_n.status = ST_MAGIC;
			end else if (version_n != expected_version) begin
				res_n.status = ST_VERSION;
			end else if ({1'b0, length_n} != count_n) begin
				res_n.status = ST_LENGTH;
			end else begin
				res_n.status = ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_ok_q  <= 1'b1;
			version_q   <= '0;
			type_q      <= '0;
			length_q    <= '0;
			seq_q       <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_item.last) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (q_item.last) begin
					magic_ok_q <= 1'b1;
					version_q  <= '0;
					type_q     <= '0;
					length_q   <= '0;
					seq_q      <= '0;
					count_q    <= '0;
				end else begin
					magic_ok_q <= magic_ok_n;
					version_q  <= version_n;
					type_q     <= type_n;
					length_q   <= length_n;
					seq_q      <= seq_n;
					count_q    <= count_n;
				end
			end
		end
	end

endmodule

/* rtl/core/packet_header_checker_unit.sv */
// Top level of the packet header checker: config registers, front, queue, back.
// Depends on phc_pkg, phc_front, phc_queue, phc_back.
//
//  channel | signals                                   | handshake
//  in      | data_byte, last_byte                      | in_valid / in_ready
//  out     | status, msg_type, declared_length,        | out_valid / out_ready
//          | sequence_res, version_seen                |
//  cfg     | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
// One byte per cycle while in_ready is high; a packet's last byte, once accepted,
// is registered in the queue, then its result in the back end's result register.
// Reset clears header position, queue and capture state; magic_word 0, version 1.
// An output stall holds the back end on a last byte; the queue then fills and
// drops in_ready. Config writes are always taken.
module packet_header_checker_unit #(
	parameter int MAGIC_BYTES = phc_pkg::MAGIC_BYTES_DEF,
	parameter int QUEUE_DEPTH = phc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  msg_type,
	output logic [15:0] declared_length,
	output logic [31:0] sequence_res,
	output logic [7:0]  version_seen,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import phc_pkg::*;

	logic [31:0] magic_word_q;
	logic [7:0]  exp_version_q;
	logic        accept;
	logic        q_full;
	logic        q_valid;
	logic        q_pop;
	item_t       front_item;
	item_t       q_item;
	result_t     res;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q  <= '0;
			exp_version_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAGIC:   magic_word_q  <= cfg_data;
				REG_VERSION: exp_version_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	phc_front #(
		.MAGIC_BYTES(MAGIC_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.magic_word(magic_word_q),
		.item      (front_item)
	);

	phc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_item(front_item),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.head     (q_item)
	);

	phc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.expected_version(exp_version_q),
		.res_valid       (out_valid),
		.res_ready       (out_ready),
		.res             (res)
	);

	assign status          = res.status;
	assign msg_type        = res.msg_type;
	assign declared_length = res.declared_length;
	assign sequence_res    = res.sequence_res;
	assign version_seen    = res.version_seen;

endmodule

/* rtl/core/phc_checker.sv */
// Port-level checks for the packet header checker, bound to the top level.
// Depends on phc_pkg and packet_header_checker_unit_macros.svh.
`include "packet_header_checker_unit_macros.svh"

module phc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [7:0]  msg_type,
	input logic [15:0] declared_length,
	input logic [31:0] sequence_res,
	input logic [7:0]  version_seen
);
	import phc_pkg::*;

	logic [66:0] res_fields;
	logic [63:0] hdr_fields;

	assign hdr_fields = {msg_type, declared_length, sequence_res, version_seen};
	assign res_fields = {status, hdr_fields};

	`PHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`PHC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(res_fields))
	`PHC_ASSERT_NOW(a_status_code, out_valid, status <= ST_LENGTH)
	`PHC_ASSERT_NOW(a_trunc_zero, out_valid && status == ST_TRUNC, hdr_fields == '0)

endmodule

bind packet_header_checker_unit phc_checker u_phc_checker (.*);
